@@ hw/rtl/pfwc_pkg.sv @@
// shared types, constants and helper functions for the pll frequency word calculator
// no dependencies; used by pfwc_ctrl, pfwc_dp and the top level
`default_nettype none

package pfwc_pkg;

  // input clamp range, tenths of a MHz
  localparam logic [15:0] FREQ_MIN = 16'd350;
  localparam logic [15:0] FREQ_MAX = 16'd44000;

  // vco window in whole MHz
  localparam logic [12:0] VCO_LOW  = 13'd2200;
  localparam logic [12:0] VCO_HIGH = 13'd4400;

  localparam logic [9:0]  MOD_START   = 10'd1000;
  localparam logic [2:0]  DIV_EXP_MAX = 3'd6;

  // reciprocal constants: x/10 = (x*52429)>>19 for x<=44000,
  // x/1000 ~ (x*16777)>>24 (low by at most one), x/5 = (x*205)>>10 for x<1024
  localparam logic [15:0] RECIP_10    = 16'd52429;
  localparam logic [14:0] RECIP_1000  = 15'd16777;
  localparam logic [7:0]  RECIP_5     = 8'd205;
  localparam logic [10:0] TEN_HUNDRED = 11'd1000;

  // configuration register indexes
  localparam logic [1:0] CFG_RF_OFF  = 2'd0;
  localparam logic [1:0] CFG_R1_BASE = 2'd1;
  localparam logic [1:0] CFG_R4_ON   = 2'd2;

  // emitted word order
  localparam logic [1:0] WORD_RF_OFF = 2'd0;
  localparam logic [1:0] WORD_R0     = 2'd1;
  localparam logic [1:0] WORD_R1     = 2'd2;
  localparam logic [1:0] WORD_R4     = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MHZ,
    OP_SEARCH,
    OP_TOTAL,
    OP_RECIP,
    OP_REM,
    OP_FIX,
    OP_RED5,
    OP_RED2,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] word_idx;
  } cmd_t;

  typedef struct packed {
    logic vco_ok;
    logic k_max;
    logic red5_ok;
    logic red2_ok;
    logic out_stall;
  } stat_t;

  function automatic logic [9:0] div5(input logic [9:0] x);
    logic [17:0] prod;
    prod = {8'd0, x} * {10'd0, RECIP_5};
    return {2'd0, prod[17:10]};
  endfunction

  function automatic logic is_mult5(input logic [9:0] x);
    logic [11:0] back;
    back = {2'd0, div5(x)} * 12'd5;
    return back == {2'd0, x};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pfwc_ctrl.sv @@
// sequencing state machine of the pll frequency word calculator
// depends on pfwc_pkg for the command and status structs
`default_nettype none

module pfwc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pfwc_pkg::stat_t stat,
  output pfwc_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MHZ,
    S_SEARCH,
    S_TOTAL,
    S_RECIP,
    S_REM,
    S_FIX,
    S_RED5,
    S_RED2,
    S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd.op       = pfwc_pkg::OP_NONE;
    cmd.word_idx = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = pfwc_pkg::OP_LOAD;
          state_nxt = S_MHZ;
        end
      end
      S_MHZ: begin
        cmd.op    = pfwc_pkg::OP_MHZ;
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (stat.vco_ok || stat.k_max) begin
          state_nxt = S_TOTAL;
        end else begin
          cmd.op = pfwc_pkg::OP_SEARCH;
        end
      end
      S_TOTAL: begin
        cmd.op    = pfwc_pkg::OP_TOTAL;
        state_nxt = S_RECIP;
      end
      S_RECIP: begin
        cmd.op    = pfwc_pkg::OP_RECIP;
        state_nxt = S_REM;
      end
      S_REM: begin
        cmd.op    = pfwc_pkg::OP_REM;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.op    = pfwc_pkg::OP_FIX;
        state_nxt = S_RED5;
      end
      S_RED5: begin
        if (stat.red5_ok) begin
          cmd.op = pfwc_pkg::OP_RED5;
        end else begin
          state_nxt = S_RED2;
        end
      end
      S_RED2: begin
        if (stat.red2_ok) begin
          cmd.op = pfwc_pkg::OP_RED2;
        end else begin
          state_nxt = S_EMIT;
          idx_nxt   = pfwc_pkg::WORD_RF_OFF;
        end
      end
      S_EMIT: begin
        if (!stat.out_stall) begin
          cmd.op  = pfwc_pkg::OP_EMIT;
          idx_nxt = idx_r + 2'd1;
          if (idx_r == pfwc_pkg::WORD_R4) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= pfwc_pkg::WORD_RF_OFF;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/pfwc_dp.sv @@
// datapath of the pll frequency word calculator: clamp, divider search,
// int/frac split, fraction reduction, config registers and output register
// depends on pfwc_pkg
`default_nettype none

module pfwc_dp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [15:0]     in_freq_tenths,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [31:0]     cfg_wdata,
  input  wire pfwc_pkg::cmd_t  cmd,
  output pfwc_pkg::stat_t      stat,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [31:0]          out_register_word,
  output logic [1:0]           out_word_index,
  output logic                 out_last_word
);

  logic [31:0] rf_off_r, r1_base_r, r4_on_r;
  logic [15:0] f_r;
  logic [12:0] p_r;
  logic [2:0]  k_r;
  logic [23:0] total_r;
  logic [13:0] q_r;
  logic [10:0] rem_r;
  logic [9:0]  frac_r, mod_r;
  logic        out_valid_r;
  logic [31:0] word_r;
  logic [1:0]  widx_r;
  logic        last_r;

  logic [15:0] f_clamp;
  logic [31:0] mhz_prod;
  logic [38:0] recip_prod;
  logic [23:0] rem_full;
  logic [31:0] r0_word, r1_word, r4_word, word_sel;

  always_comb begin
    f_clamp = in_freq_tenths;
    if (in_freq_tenths < pfwc_pkg::FREQ_MIN) begin
      f_clamp = pfwc_pkg::FREQ_MIN;
    end else if (in_freq_tenths > pfwc_pkg::FREQ_MAX) begin
      f_clamp = pfwc_pkg::FREQ_MAX;
    end
  end

  assign mhz_prod   = {16'd0, f_r} * {16'd0, pfwc_pkg::RECIP_10};
  assign recip_prod = {15'd0, total_r} * {24'd0, pfwc_pkg::RECIP_1000};
  assign rem_full   = total_r - ({10'd0, q_r} * 24'd1000);

  assign r0_word = {3'd0, q_r, 15'd0} + {19'd0, frac_r, 3'd0};
  assign r1_word = r1_base_r + {19'd0, mod_r, 3'd0};
  assign r4_word = r4_on_r + {9'd0, k_r, 20'd0};

  always_comb begin
    unique case (cmd.word_idx)
      pfwc_pkg::WORD_RF_OFF: word_sel = rf_off_r;
      pfwc_pkg::WORD_R0:     word_sel = r0_word;
      pfwc_pkg::WORD_R1:     word_sel = r1_word;
      pfwc_pkg::WORD_R4:     word_sel = r4_word;
      default:               word_sel = rf_off_r;
    endcase
  end

  assign stat.vco_ok    = (p_r >= pfwc_pkg::VCO_LOW) && (p_r <= pfwc_pkg::VCO_HIGH);
  assign stat.k_max     = (k_r == pfwc_pkg::DIV_EXP_MAX);
  assign stat.red5_ok   = pfwc_pkg::is_mult5(frac_r) && pfwc_pkg::is_mult5(mod_r);
  assign stat.red2_ok   = !frac_r[0] && !mod_r[0];
  assign stat.out_stall = out_valid_r && !out_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_off_r  <= 32'd0;
      r1_base_r <= 32'd0;
      r4_on_r   <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfwc_pkg::CFG_RF_OFF:  rf_off_r  <= cfg_wdata;
        pfwc_pkg::CFG_R1_BASE: r1_base_r <= cfg_wdata;
        pfwc_pkg::CFG_R4_ON:   r4_on_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      pfwc_pkg::OP_LOAD: begin
        f_r <= f_clamp;
        k_r <= 3'd0;
      end
      pfwc_pkg::OP_MHZ: begin
        p_r <= mhz_prod[31:19];
      end
      pfwc_pkg::OP_SEARCH: begin
        p_r <= {p_r[11:0], 1'b0};
        k_r <= k_r + 3'd1;
      end
      pfwc_pkg::OP_TOTAL: begin
        total_r <= ({8'd0, f_r} << k_r) << 2;
      end
      pfwc_pkg::OP_RECIP: begin
        q_r <= recip_prod[37:24];
      end
      pfwc_pkg::OP_REM: begin
        rem_r <= rem_full[10:0];
      end
      pfwc_pkg::OP_FIX: begin
        // estimate is low by at most one
        if (rem_r >= pfwc_pkg::TEN_HUNDRED) begin
          q_r    <= q_r + 14'd1;
          frac_r <= 10'(rem_r - pfwc_pkg::TEN_HUNDRED);
        end else begin
          frac_r <= rem_r[9:0];
        end
        mod_r <= pfwc_pkg::MOD_START;
      end
      pfwc_pkg::OP_RED5: begin
        frac_r <= pfwc_pkg::div5(frac_r);
        mod_r  <= pfwc_pkg::div5(mod_r);
      end
      pfwc_pkg::OP_RED2: begin
        frac_r <= {1'b0, frac_r[9:1]};
        mod_r  <= {1'b0, mod_r[9:1]};
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == pfwc_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pfwc_pkg::OP_EMIT) begin
      word_r <= word_sel;
      widx_r <= cmd.word_idx;
      last_r <= (cmd.word_idx == pfwc_pkg::WORD_R4);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_register_word = word_r;
  assign out_word_index    = widx_r;
  assign out_last_word     = last_r;

endmodule

`default_nettype wire

@@ hw/rtl/pll_frequency_word_calculator.sv @@
// top level of the pll frequency word calculator
// instantiates pfwc_ctrl and pfwc_dp; uses pfwc_pkg
`default_nettype none

// Turns a target frequency in tenths of a MHz (clamped to 35.0..4400.0 MHz)
// into the four 32-bit synthesizer register words, delivered in order:
// rf-off, R0 (INT and FRAC), R1 (base plus reduced MOD) and R4 (base plus
// output divider exponent); the fourth word carries out_last_word. One item
// at a time is worked on: the state machine walks through the whole-MHz
// step, the divider search, the int/frac split, the factor-of-5 reduction,
// the factor-of-2 reduction (FRAC is always a multiple of four) and the four
// word emits, and an output stall holds it in the emits. The last word sits
// in an output register, so in_ready rises while it still waits to be taken.
// Configuration writes (rf_off, r1_base, r4_on at indexes 0..2) take effect
// at once and are meant to happen while no item is in flight.

module pll_frequency_word_calculator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_freq_tenths,
  // result item channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_register_word,
  output logic [1:0]       out_word_index,
  output logic             out_last_word,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  pfwc_pkg::cmd_t  cmd;
  pfwc_pkg::stat_t stat;

  // controller: walks clamp, search, split, reduce and emit steps
  pfwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: arithmetic, config registers and the output register
  pfwc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_freq_tenths    (in_freq_tenths),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_register_word (out_register_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  logic in_take, out_take;
  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  // an accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> !in_ready)
    else $error("in_ready high right after an item was accepted");

  // once a non-final word is taken, the next word is loaded right away
  a_words_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && !out_last_word |=> out_valid)
    else $error("gap in the word sequence of an item");

  // the last flag marks only the R4 word
  a_last_is_r4: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == pfwc_pkg::WORD_R4)))
    else $error("last_word does not match word index");

endmodule

`default_nettype wire
